@@ rtl/core/tsm_pkg.sv @@
// Package for the two-way sorted merge: sizes, operation codes and state type.
package tsm_pkg;

    // Keys per list and derived widths
    localparam int LIST_DEPTH = 256;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int KEY_W      = 64;
    localparam int OP_W       = 2;

    // Operation codes carried by an input beat
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_POP    = 2'd2
    } t_op;

    // Sequencer states
    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [KEY_W-1:0]  t_key;

endpackage

@@ rtl/core/tsm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module tsm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/two_way_sorted_merge.sv @@
// Top level of the two-way sorted merge: list memories, head logic, output register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_operation, i_key_in
//  out     | output    | o_out_valid / i_out_ready  | o_key_out, o_is_last, o_is_empty
//
// A load beat writes the key straight into its list memory.
// A pop beat reads the heads of both memories at acceptance; they are compared in
// S_POP, once the registered read data has arrived and the output register is free.
// A pop waits in S_POP while the output register holds a result not yet taken.
// Reset (synchronous, active low) clears state, counts, heads, drain flag and valid;
// the memories need no clearing, as only entries below a count are ever used.
module two_way_sorted_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_operation,
    input  logic signed [63:0]   i_key_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [63:0]   o_key_out,
    output logic                 o_is_last,
    output logic                 o_is_empty
);

    import tsm_pkg::*;

    t_state r_state, n_state;
    t_cnt   r_count_a, n_count_a, r_count_b, n_count_b;
    t_cnt   r_head_a, n_head_a, r_head_b, n_head_b;
    logic   r_draining, n_draining;

    logic   r_out_valid, n_out_valid;
    t_key   r_key_out, n_key_out;
    logic   r_is_last, n_is_last, r_is_empty, n_is_empty;

    logic   w_accept;
    logic   w_pop_issue;
    logic   w_we_a, w_we_b;
    t_key   w_rd_a, w_rd_b;
    logic   w_out_free;
    logic   w_out_load;
    logic   w_a_left, w_b_left, w_take_a, w_last;
    t_cnt   w_head_a_inc, w_head_b_inc;

    // List memories
    tsm_ram #(.WIDTH(KEY_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (r_count_a[ADDR_W-1:0]),
        .i_wdata (i_key_in),
        .i_re    (w_pop_issue),
        .i_raddr (r_head_a[ADDR_W-1:0]),
        .o_rdata (w_rd_a)
    );

    tsm_ram #(.WIDTH(KEY_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (r_count_b[ADDR_W-1:0]),
        .i_wdata (i_key_in),
        .i_re    (w_pop_issue),
        .i_raddr (r_head_b[ADDR_W-1:0]),
        .o_rdata (w_rd_b)
    );

    // Handshake and output register occupancy
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Head comparison; B wins on equal keys
    assign w_a_left     = r_head_a < r_count_a;
    assign w_b_left     = r_head_b < r_count_b;
    assign w_take_a     = w_a_left && (!w_b_left || ($signed(w_rd_a) < $signed(w_rd_b)));
    assign w_head_a_inc = r_head_a + t_cnt'(1);
    assign w_head_b_inc = r_head_b + t_cnt'(1);
    assign w_last       = w_take_a
                        ? (w_head_a_inc >= r_count_a) && !w_b_left
                        : (w_head_b_inc >= r_count_b) && !w_a_left;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_operation == OP_POP) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer
    always_comb begin
        o_in_ready  = 1'b0;
        w_pop_issue = 1'b0;
        w_we_a      = 1'b0;
        w_we_b      = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                w_pop_issue = w_accept && i_operation == OP_POP;
                w_we_a      = w_accept && i_operation == OP_LOAD_A && !r_draining
                              && r_count_a < t_cnt'(LIST_DEPTH);
                w_we_b      = w_accept && i_operation == OP_LOAD_B && !r_draining
                              && r_count_b < t_cnt'(LIST_DEPTH);
            end
            S_POP: begin
                w_out_load = w_out_free;
            end
            default: ;
        endcase
    end

    // List bookkeeping and result formation
    always_comb begin
        n_count_a   = r_count_a;
        n_count_b   = r_count_b;
        n_head_a    = r_head_a;
        n_head_b    = r_head_b;
        n_draining  = r_draining;
        n_out_valid = r_out_valid && !i_out_ready;
        n_key_out   = r_key_out;
        n_is_last   = r_is_last;
        n_is_empty  = r_is_empty;

        if (w_we_a) begin
            n_count_a = r_count_a + t_cnt'(1);
        end
        if (w_we_b) begin
            n_count_b = r_count_b + t_cnt'(1);
        end

        if (w_out_load) begin
            n_out_valid = 1'b1;
            if (!w_a_left && !w_b_left) begin
                // nothing left: empty beat, state untouched
                n_key_out  = '0;
                n_is_last  = 1'b0;
                n_is_empty = 1'b1;
            end else begin
                n_key_out  = w_take_a ? w_rd_a : w_rd_b;
                n_is_last  = w_last;
                n_is_empty = 1'b0;
                n_draining = 1'b1;
                if (w_take_a) begin
                    n_head_a = w_head_a_inc;
                end else begin
                    n_head_b = w_head_b_inc;
                end
                if (w_last) begin
                    // final key: both lists clear for a new load phase
                    n_count_a  = '0;
                    n_count_b  = '0;
                    n_head_a   = '0;
                    n_head_b   = '0;
                    n_draining = 1'b0;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count_a   <= '0;
            r_count_b   <= '0;
            r_head_a    <= '0;
            r_head_b    <= '0;
            r_draining  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count_a   <= n_count_a;
            r_count_b   <= n_count_b;
            r_head_a    <= n_head_a;
            r_head_b    <= n_head_b;
            r_draining  <= n_draining;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_key_out  <= n_key_out;
        r_is_last  <= n_is_last;
        r_is_empty <= n_is_empty;
    end

    assign o_out_valid = r_out_valid;
    assign o_key_out   = r_key_out;
    assign o_is_last   = r_is_last;
    assign o_is_empty  = r_is_empty;

`ifndef SYNTHESIS
    // A beat is never both last and empty
    a_last_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_last && o_is_empty))
        else $error("last and empty flagged together");

    // An empty beat carries a zero key
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_key_out == '0))
        else $error("empty beat with non-zero key");

    // Heads never run past the counts
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head_a <= r_count_a) && (r_head_b <= r_count_b))
        else $error("head beyond count");

    // After the last key both lists are cleared
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && (w_a_left || w_b_left) && w_last) |=>
        (r_count_a == '0 && r_count_b == '0 && !r_draining))
        else $error("lists not cleared after last key");

    // Memories are never written while a pop is in flight
    a_no_write_in_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> !(w_we_a || w_we_b))
        else $error("list written during pop");
`endif

endmodule
